[hdl/fte_pkg.sv]
// ============================================================================
// FIX tag extractor package
// Shared types, character constants and decode functions for the extractor.
// ============================================================================
`default_nettype none

package fte_pkg;

  // Character constants.
  localparam logic [7:0] SOH_CHAR   = 8'h01;
  localparam logic [7:0] EQ_CHAR    = 8'h3D;
  localparam logic [7:0] DIGIT_LO   = 8'h30;
  localparam logic [7:0] DIGIT_HI   = 8'h39;
  localparam int unsigned PREFIX_LEN = 5;
  localparam logic [15:0] MIN_FIX_LEN = 16'd7;
  localparam logic [15:0] LEN_MAX     = 16'hFFFF;

  // Default truncation length of a streamed value.
  localparam int unsigned MAX_VALUE_CHARS_DEF = 15;

  // Result queue depth (power of two).
  localparam int unsigned RESULT_FIFO_DEPTH = 4;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_TAG   = 2'd1,
    PH_VALUE = 2'd2,
    PH_SKIP  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    TGT_TICKER = 3'd0,
    TGT_QTY    = 3'd1,
    TGT_PRICE  = 3'd2,
    TGT_TYPE   = 3'd3,
    TGT_SIDE   = 3'd4,
    TGT_NONE   = 3'd7
  } target_e;

  typedef enum logic [2:0] {
    KIND_NEW_ORDER   = 3'd0,
    KIND_CANCEL      = 3'd1,
    KIND_MODIFY      = 3'd2,
    KIND_EXEC_REPORT = 3'd3,
    KIND_MD_REQUEST  = 3'd4,
    KIND_SNAPSHOT    = 3'd5,
    KIND_INCREMENTAL = 3'd6,
    KIND_UNKNOWN     = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    SIDE_UNKNOWN = 2'd0,
    SIDE_BUY     = 2'd1,
    SIDE_SELL    = 2'd2
  } side_e;

  typedef enum logic {
    RK_VALUE   = 1'b0,
    RK_SUMMARY = 1'b1
  } rkind_e;

  // One result word as it leaves the block.
  typedef struct packed {
    rkind_e      kind;
    logic [1:0]  field_id;
    logic [7:0]  value_char;
    logic [3:0]  char_index;
    logic        is_fix;
    kind_e       msg_kind;
    side_e       side_code;
    logic        found_ticker;
    logic        found_quantity;
    logic        found_price;
    logic [15:0] payload_length;
    logic        last_of_run;
  } result_t;

  // Expected character at each position of the "8=FIX" prefix.
  function automatic logic [7:0] prefix_char(input logic [2:0] pos);
    logic [7:0] c;
    unique case (pos)
      3'd0:    c = 8'h38;
      3'd1:    c = 8'h3D;
      3'd2:    c = 8'h46;
      3'd3:    c = 8'h49;
      3'd4:    c = 8'h58;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Map a two-digit tag number to the field it feeds.
  function automatic target_e target_of_tag(input logic [6:0] tag);
    target_e t;
    unique case (tag)
      7'd55:   t = TGT_TICKER;
      7'd38:   t = TGT_QTY;
      7'd44:   t = TGT_PRICE;
      7'd35:   t = TGT_TYPE;
      7'd54:   t = TGT_SIDE;
      default: t = TGT_NONE;
    endcase
    return t;
  endfunction

  // Message type: only a single character is recognized.
  function automatic kind_e classify_type(input logic [7:0] c, input logic [1:0] len);
    kind_e k;
    if (len != 2'd1) begin
      k = KIND_UNKNOWN;
    end else begin
      unique case (c)
        8'h44:   k = KIND_NEW_ORDER;
        8'h46:   k = KIND_CANCEL;
        8'h47:   k = KIND_MODIFY;
        8'h38:   k = KIND_EXEC_REPORT;
        8'h56:   k = KIND_MD_REQUEST;
        8'h57:   k = KIND_SNAPSHOT;
        8'h58:   k = KIND_INCREMENTAL;
        default: k = KIND_UNKNOWN;
      endcase
    end
    return k;
  endfunction

  // Side: a single '1' or '2'.
  function automatic side_e classify_side(input logic [7:0] c, input logic [1:0] len);
    side_e s;
    s = SIDE_UNKNOWN;
    if (len == 2'd1) begin
      if (c == 8'h31) s = SIDE_BUY;
      else if (c == 8'h32) s = SIDE_SELL;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

[hdl/fte_parser.sv]
// ============================================================================
// FIX tag extractor parser
// Per-byte tag/value parse state and result generation, one byte per cycle while step_i is high.
// ============================================================================
`default_nettype none

module fte_parser import fte_pkg::*; #(
  parameter int unsigned MaxValueChars = MAX_VALUE_CHARS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       last_i,
  output result_t         res_a_o,
  output result_t         res_b_o,
  output logic [1:0]      push_cnt_o
);

  localparam logic [3:0] MaxChars = 4'(MaxValueChars);

  logic [2:0]  prefix_pos_q, prefix_pos_d;
  logic        prefix_good_q, prefix_good_d;
  logic [15:0] byte_count_q, byte_count_d;
  phase_e      phase_q, phase_d;
  logic [6:0]  tag_number_q, tag_number_d;
  logic [1:0]  tag_digits_q, tag_digits_d;
  target_e     target_q, target_d;
  logic [3:0]  vcount_q, vcount_d;
  logic [4:0]  found_q, found_d;
  logic [7:0]  type_char_q, type_char_d;
  logic [1:0]  type_len_q, type_len_d;
  logic [7:0]  side_char_q, side_char_d;
  logic [1:0]  side_len_q, side_len_d;

  target_e     match_tgt;
  logic        match_seen;
  logic        char_vld;
  logic        is_fix;
  result_t     char_res;
  result_t     sum_res;

  // Tag lookup: exactly two digits without a leading zero.
  always_comb begin
    match_tgt = TGT_NONE;
    if (tag_digits_q == 2'd2 && tag_number_q >= 7'd10) begin
      match_tgt = target_of_tag(tag_number_q);
    end
    match_seen = |(found_q & (5'b1 << match_tgt));
  end

  // Next state after this byte has been parsed.
  always_comb begin
    prefix_pos_d  = prefix_pos_q;
    prefix_good_d = prefix_good_q;
    byte_count_d  = byte_count_q;
    phase_d       = phase_q;
    tag_number_d  = tag_number_q;
    tag_digits_d  = tag_digits_q;
    target_d      = target_q;
    vcount_d      = vcount_q;
    found_d       = found_q;
    type_char_d   = type_char_q;
    type_len_d    = type_len_q;
    side_char_d   = side_char_q;
    side_len_d    = side_len_q;

    if (byte_count_q != LEN_MAX) byte_count_d = byte_count_q + 16'd1;

    if (prefix_pos_q < 3'(PREFIX_LEN)) begin
      if (byte_i != prefix_char(prefix_pos_q)) prefix_good_d = 1'b0;
      prefix_pos_d = prefix_pos_q + 3'd1;
    end

    if (byte_i == SOH_CHAR) begin
      phase_d      = PH_TAG;
      tag_number_d = 7'd0;
      tag_digits_d = 2'd0;
      target_d     = TGT_NONE;
      vcount_d     = 4'd0;
    end else begin
      unique case (phase_q)
        PH_TAG: begin
          if (byte_i >= DIGIT_LO && byte_i <= DIGIT_HI) begin
            if (tag_digits_q < 2'd2) begin
              tag_number_d = tag_number_q * 7'd10 + {3'b000, byte_i[3:0]};
            end
            if (tag_digits_q < 2'd3) tag_digits_d = tag_digits_q + 2'd1;
          end else if (byte_i == EQ_CHAR) begin
            if (prefix_good_d && match_tgt != TGT_NONE && !match_seen) begin
              found_d  = found_q | (5'b1 << match_tgt);
              target_d = match_tgt;
              vcount_d = 4'd0;
              phase_d  = PH_VALUE;
            end else begin
              phase_d = PH_SKIP;
            end
          end else begin
            phase_d = PH_SKIP;
          end
        end
        PH_VALUE: begin
          if (target_q == TGT_TICKER || target_q == TGT_QTY || target_q == TGT_PRICE) begin
            if (vcount_q < MaxChars) vcount_d = vcount_q + 4'd1;
          end else if (target_q == TGT_TYPE) begin
            if (type_len_q == 2'd0) type_char_d = byte_i;
            if (type_len_q < 2'd2) type_len_d = type_len_q + 2'd1;
          end else if (target_q == TGT_SIDE) begin
            if (side_len_q == 2'd0) side_char_d = byte_i;
            if (side_len_q < 2'd2) side_len_d = side_len_q + 2'd1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Results: a value character, then the summary when the payload ends.
  always_comb begin
    char_vld = step_i && byte_i != SOH_CHAR && phase_q == PH_VALUE &&
               (target_q == TGT_TICKER || target_q == TGT_QTY || target_q == TGT_PRICE) &&
               vcount_q < MaxChars;

    char_res            = '0;
    char_res.kind       = RK_VALUE;
    char_res.field_id   = target_q[1:0];
    char_res.value_char = byte_i;
    char_res.char_index = vcount_q;
    char_res.msg_kind   = KIND_NEW_ORDER;
    char_res.side_code  = SIDE_UNKNOWN;

    is_fix                 = prefix_good_d && byte_count_d >= MIN_FIX_LEN;
    sum_res                = '0;
    sum_res.kind           = RK_SUMMARY;
    sum_res.is_fix         = is_fix;
    sum_res.msg_kind       = is_fix ? classify_type(type_char_d, type_len_d) : KIND_UNKNOWN;
    sum_res.side_code      = is_fix ? classify_side(side_char_d, side_len_d) : SIDE_UNKNOWN;
    sum_res.found_ticker   = is_fix && found_d[TGT_TICKER];
    sum_res.found_quantity = is_fix && found_d[TGT_QTY];
    sum_res.found_price    = is_fix && found_d[TGT_PRICE];
    sum_res.payload_length = byte_count_d;
    sum_res.last_of_run    = 1'b1;

    res_a_o    = char_vld ? char_res : sum_res;
    res_b_o    = sum_res;
    push_cnt_o = {1'b0, char_vld} + {1'b0, step_i && last_i};
  end

  // Parse state; everything returns to its reset value after a summary.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_pos_q  <= 3'd0;
      prefix_good_q <= 1'b1;
      byte_count_q  <= 16'd0;
      phase_q       <= PH_FIRST;
      tag_number_q  <= 7'd0;
      tag_digits_q  <= 2'd0;
      target_q      <= TGT_NONE;
      vcount_q      <= 4'd0;
      found_q       <= 5'd0;
      type_char_q   <= 8'd0;
      type_len_q    <= 2'd0;
      side_char_q   <= 8'd0;
      side_len_q    <= 2'd0;
    end else if (step_i) begin
      if (last_i) begin
        prefix_pos_q  <= 3'd0;
        prefix_good_q <= 1'b1;
        byte_count_q  <= 16'd0;
        phase_q       <= PH_FIRST;
        tag_number_q  <= 7'd0;
        tag_digits_q  <= 2'd0;
        target_q      <= TGT_NONE;
        vcount_q      <= 4'd0;
        found_q       <= 5'd0;
        type_char_q   <= 8'd0;
        type_len_q    <= 2'd0;
        side_char_q   <= 8'd0;
        side_len_q    <= 2'd0;
      end else begin
        prefix_pos_q  <= prefix_pos_d;
        prefix_good_q <= prefix_good_d;
        byte_count_q  <= byte_count_d;
        phase_q       <= phase_d;
        tag_number_q  <= tag_number_d;
        tag_digits_q  <= tag_digits_d;
        target_q      <= target_d;
        vcount_q      <= vcount_d;
        found_q       <= found_d;
        type_char_q   <= type_char_d;
        type_len_q    <= type_len_d;
        side_char_q   <= side_char_d;
        side_len_q    <= side_len_d;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/fte_result_fifo.sv]
// ============================================================================
// FIX tag extractor result queue
// Small register queue that takes up to two results a cycle and hands out one while the output is ready.
// ============================================================================
`default_nettype none

module fte_result_fifo import fte_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_cnt_i,
  input  wire result_t    wdata_a_i,
  input  wire result_t    wdata_b_i,
  output logic            room2_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output result_t         rdata_o
);

  localparam int unsigned PtrW = $clog2(RESULT_FIFO_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  result_t            mem_q [RESULT_FIFO_DEPTH];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [PtrW-1:0]    wr_ptr_b;
  logic               pop;

  // Pointer and fill-count bookkeeping.
  always_comb begin
    pop      = out_valid_o && out_ready_i;
    wr_ptr_b = wr_ptr_q + PtrW'(1);
    wr_ptr_d = wr_ptr_q + PtrW'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_cnt_i) - CntW'(pop);
  end

  assign room2_o     = count_q <= CntW'(RESULT_FIFO_DEPTH - 2);
  assign out_valid_o = count_q != '0;
  assign rdata_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage: the first result goes to the write pointer, a second one after it.
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) mem_q[wr_ptr_q] <= wdata_a_i;
    if (push_cnt_i == 2'd2) mem_q[wr_ptr_b] <= wdata_b_i;
  end

endmodule

`default_nettype wire

[hdl/fix_tag_field_extractor_unit.sv]
// ============================================================================
// FIX tag field extractor
// Streams ticker, quantity and price characters and a per-message summary.
// ============================================================================
// The unit takes one payload byte per cycle while the result queue has room for
// two results. A byte is registered on entry, parsed once the queue has that room,
// and its results are written to a four-entry result queue. Most bytes produce at
// most one result; the final byte of a payload that is also a streamed value
// character produces two results. Since the output hands out at most one result
// per cycle, and only while out_ready_i is high, the input stalls whenever the
// queue cannot take two more results.
`default_nettype none

module fix_tag_field_extractor_unit import fte_pkg::*; #(
  parameter int unsigned MaxValueChars = MAX_VALUE_CHARS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  payload_byte_i,
  input  wire logic        end_of_payload_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             result_kind_o,
  output logic [1:0]       field_id_o,
  output logic [7:0]       value_char_o,
  output logic [3:0]       char_index_o,
  output logic             is_fix_o,
  output logic [2:0]       msg_kind_o,
  output logic [1:0]       side_code_o,
  output logic             found_ticker_o,
  output logic             found_quantity_o,
  output logic             found_price_o,
  output logic [15:0]      payload_length_o,
  output logic             last_of_run_o
);

  logic       st_vld_q, st_vld_d;
  logic [7:0] st_byte_q;
  logic       st_last_q;
  logic       room2;
  logic       step;
  logic       in_acc;
  logic [1:0] push_cnt;
  result_t    res_a;
  result_t    res_b;
  result_t    head;

  // Input stage: a word moves on when the queue has room for two results.
  assign step       = st_vld_q && room2;
  assign in_ready_o = !st_vld_q || room2;
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    st_vld_d = st_vld_q;
    if (in_acc) st_vld_d = 1'b1;
    else if (step) st_vld_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_vld_q <= 1'b0;
    end else begin
      st_vld_q <= st_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      st_byte_q <= payload_byte_i;
      st_last_q <= end_of_payload_i;
    end
  end

  fte_parser #(
    .MaxValueChars(MaxValueChars)
  ) u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .byte_i    (st_byte_q),
    .last_i    (st_last_q),
    .res_a_o   (res_a),
    .res_b_o   (res_b),
    .push_cnt_o(push_cnt)
  );

  fte_result_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (push_cnt),
    .wdata_a_i  (res_a),
    .wdata_b_i  (res_b),
    .room2_o    (room2),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .rdata_o    (head)
  );

  // Result word onto the output ports.
  assign result_kind_o    = head.kind;
  assign field_id_o       = head.field_id;
  assign value_char_o     = head.value_char;
  assign char_index_o     = head.char_index;
  assign is_fix_o         = head.is_fix;
  assign msg_kind_o       = head.msg_kind;
  assign side_code_o      = head.side_code;
  assign found_ticker_o   = head.found_ticker;
  assign found_quantity_o = head.found_quantity;
  assign found_price_o    = head.found_price;
  assign payload_length_o = head.payload_length;
  assign last_of_run_o    = head.last_of_run;

endmodule

`default_nettype wire
